// ===== src/etap_pkg.sv =====
// ---------------------------------------------------------------------------
// ESC arming and pulse generator - shared package
// Field widths, register indexes, reset values, controller encodings and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package etap_pkg;

  // Item field widths
  localparam int KIND_W  = 2;
  localparam int THR_W   = 11;
  localparam int PULSE_W = 12;
  localparam int F_W     = 27;  // filter state, Q11.16 signed

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_UPDATE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FAILSAFE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START    = 2'd2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL  = 3'd5;

  // Register reset values
  localparam logic [15:0]        RST_ALPHA    = 16'd13107;
  localparam logic [9:0]         RST_DEADBAND = 10'd50;
  localparam logic [15:0]        RST_GAIN     = 16'd32768;
  localparam logic [PULSE_W-1:0] RST_MIN      = 12'd1000;
  localparam logic [PULSE_W-1:0] RST_MAX      = 12'd2000;
  localparam logic [PULSE_W-1:0] RST_NEUTRAL  = 12'd1500;

  // Mapping constants: offset of the throttle range, and 1/125 reciprocal
  // (ceil(2^27/125)) used after a shift by 4 to divide by 2000
  localparam logic signed [12:0] THR_OFFSET = 13'sd1000;
  localparam logic [20:0]        RECIP_125  = 21'd1073742;

  // Operating mode
  typedef enum logic [1:0] {
    MODE_BOOT,
    MODE_WAIT,
    MODE_ARMED
  } mode_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_T,
    ST_FILT,
    ST_NEUT,
    ST_CHECK,
    ST_GAIN,
    ST_SPAN,
    ST_RECIP,
    ST_EMIT
  } state_t;

  // Operand select of the shared multiplier
  typedef enum logic [2:0] {
    MS_HOLD,
    MS_F_INV,
    MS_THR,
    MS_GAIN,
    MS_SPAN,
    MS_RECIP
  } mul_sel_t;

  typedef enum logic {
    OUT_NEUTRAL,
    OUT_SCALED
  } out_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_thr;
    logic     ld_acc;
    logic     clr_f;
    logic     ld_f;
    logic     ld_out;
    out_sel_t out_sel;
    logic     out_armed;
  } cmd_t;

  typedef struct packed {
    logic arm_ok;
  } stat_t;

endpackage

// ===== src/etap_if.sv =====
// ---------------------------------------------------------------------------
// ESC arming and pulse generator - channel interfaces
// Valid/ready channels for throttle events in and pulse results out.
// ---------------------------------------------------------------------------
interface etap_in_if import etap_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [THR_W-1:0] throttle;

  modport source (output valid, kind, throttle, input ready);
  modport sink   (input valid, kind, throttle, output ready);
endinterface

interface etap_out_if import etap_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_us;
  logic               armed;

  modport source (output valid, pulse_us, armed, input ready);
  modport sink   (input valid, pulse_us, armed, output ready);
endinterface

// ===== src/esc_throttle_arming_pulse_gen_core.sv =====
// ---------------------------------------------------------------------------
// ESC arming and pulse generator - top level
// Throttle update, failsafe and start events in; neutral or mapped pulse
// widths out, with the armed flag. EMA throttle filter and arming control.
// ---------------------------------------------------------------------------
// Failsafe and start give a neutral result; an update gives a neutral result
// while waiting for neutral and a mapped one while armed; an update in boot
// gives no result. One item at a time through a single shared multiplier: a
// new item is taken only once the last one has handed over its result.
// A pending result is held in the output register while the next item runs.
// Synchronous reset: boot mode, filter zero, registers to defaults.
module esc_throttle_arming_pulse_gen_core import etap_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  etap_in_if.sink               in,
  etap_out_if.source            out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  etap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_kind   (in.kind),
    .in_ready  (in.ready),
    .out_ready (out.ready),
    .out_valid (out.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  etap_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .throttle (in.throttle),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pulse_us (out.pulse_us),
    .armed    (out.armed)
  );

  // A new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> (!out.valid || out.ready))
    else $error("result register loaded while a beat is pending");

  // An accepted update keeps the block busy for the filter steps
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    (in.valid && in.ready && in.kind == KIND_UPDATE) |=> !in.ready)
    else $error("input accepted during filter update");

  // The scaled pulse is only ever reported as armed
  a_scaled_armed: assert property (@(posedge clk) disable iff (rst)
    (cmd.ld_out && cmd.out_sel == OUT_SCALED) |-> cmd.out_armed)
    else $error("scaled pulse loaded without armed flag");

endmodule

// ===== src/etap_dp.sv =====
// ---------------------------------------------------------------------------
// ESC arming and pulse generator - datapath
// Config registers, EMA filter state, one shared 28x22 signed multiplier,
// pulse mapping with divide-by-2000 through a reciprocal, and result register.
// ---------------------------------------------------------------------------
module etap_dp import etap_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic signed [THR_W-1:0] throttle,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic [PULSE_W-1:0]      pulse_us,
  output logic                    armed
);

  localparam int MA_W = 28;
  localparam int MB_W = 22;
  localparam int P_W  = MA_W + MB_W;

  // Configuration registers
  logic [15:0]        alpha;
  logic [9:0]         deadband;
  logic [15:0]        gain;
  logic [PULSE_W-1:0] min_pulse;
  logic [PULSE_W-1:0] max_pulse;
  logic [PULSE_W-1:0] neutral_pulse;

  // Working registers
  logic signed [THR_W-1:0] thr;
  logic signed [F_W-1:0]   f;
  logic signed [43:0]      acc;
  logic signed [P_W-1:0]   prod;
  logic                    neg;

  // Combinational terms
  logic [16:0]            inv_alpha;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  xsum;
  logic signed [12:0]     xv;
  logic signed [12:0]     xp;
  logic signed [12:0]     span;
  logic signed [24:0]     sp;
  logic [24:0]            sp_mag;
  logic [19:0]            mag_sh;
  logic signed [45:0]     fsum;
  logic signed [29:0]     nf;
  logic signed [F_W-1:0]  f_sat;
  logic signed [F_W:0]    fx;
  logic [F_W:0]           f_mag;
  logic [14:0]            q15;
  logic signed [14:0]     qs;
  logic signed [14:0]     lo15;
  logic signed [14:0]     hi15;
  logic signed [14:0]     p15;
  logic [PULSE_W-1:0]     scaled;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha         <= RST_ALPHA;
      deadband      <= RST_DEADBAND;
      gain          <= RST_GAIN;
      min_pulse     <= RST_MIN;
      max_pulse     <= RST_MAX;
      neutral_pulse <= RST_NEUTRAL;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ALPHA:    alpha         <= cfg_data;
        CFG_DEADBAND: deadband      <= cfg_data[9:0];
        CFG_GAIN:     gain          <= cfg_data;
        CFG_MIN:      min_pulse     <= cfg_data[PULSE_W-1:0];
        CFG_MAX:      max_pulse     <= cfg_data[PULSE_W-1:0];
        CFG_NEUTRAL:  neutral_pulse <= cfg_data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Scaled value x = trunc(f*gain / 2^31), offset by 1000 so that -1000..1000 maps to 0..2000
  always_comb begin
    xsum = prod + (prod[P_W-1] ? 50'sd2147483647 : 50'sd0);
    xv   = xsum[43:31];
    xp   = xv + THR_OFFSET;
    span = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
  end

  // Magnitude of the span product, pre-shifted by 4 (2000 = 16 * 125)
  always_comb begin
    sp     = prod[24:0];
    sp_mag = sp[24] ? 25'(-sp) : 25'(sp);
    mag_sh = sp_mag[23:4];
  end

  // Shared multiplier operand select
  always_comb begin
    inv_alpha = 17'h10000 - {1'b0, alpha};
    case (cmd.mul_sel)
      MS_F_INV: begin
        mul_a = {f[F_W-1], f};
        mul_b = {5'b0, inv_alpha};
      end
      MS_THR: begin
        mul_a = {{(MA_W-THR_W){thr[THR_W-1]}}, thr};
        mul_b = {6'b0, alpha};
      end
      MS_GAIN: begin
        mul_a = {f[F_W-1], f};
        mul_b = {6'b0, gain};
      end
      MS_SPAN: begin
        mul_a = {{15{xp[12]}}, xp};
        mul_b = {{9{span[12]}}, span};
      end
      MS_RECIP: begin
        mul_a = {8'b0, mag_sh};
        mul_b = {1'b0, RECIP_125};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MS_HOLD) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.mul_sel == MS_RECIP) begin
      neg <= sp[24];
    end
    if (cmd.ld_acc) begin
      acc <= prod[43:0];
    end
    if (cmd.ld_thr) begin
      thr <= throttle;
    end
  end

  // Filter update: round half up, then saturate to 27 bits
  always_comb begin
    fsum = {{2{acc[43]}}, acc} + {{3{prod[26]}}, prod[26:0], 16'b0} + 46'sd32768;
    nf   = fsum[45:16];
    if (nf > 30'sd67108863) begin
      f_sat = 27'sh3FFFFFF;
    end else if (nf < -30'sd67108864) begin
      f_sat = 27'sh4000000;
    end else begin
      f_sat = nf[F_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_f) begin
      f <= '0;
    end else if (cmd.ld_f) begin
      f <= f_sat;
    end
  end

  // Arming test |f| < deadband * 2^16
  always_comb begin
    fx          = {f[F_W-1], f};
    f_mag       = fx[F_W] ? 28'(-fx) : 28'(fx);
    stat.arm_ok = f_mag < {2'b0, deadband, 16'b0};
  end

  // Quotient of the span product by 2000, offset by min and clamped
  always_comb begin
    q15  = {1'b0, prod[40:27]};
    qs   = neg ? 15'(-q15) : 15'(q15);
    lo15 = $signed({3'b0, min_pulse});
    hi15 = $signed({3'b0, max_pulse});
    p15  = qs + lo15;
    if (p15 < lo15) begin
      scaled = min_pulse;
    end else if (p15 > hi15) begin
      scaled = max_pulse;
    end else begin
      scaled = p15[PULSE_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      pulse_us <= (cmd.out_sel == OUT_NEUTRAL) ? neutral_pulse : scaled;
      armed    <= cmd.out_armed;
    end
  end

endmodule

// ===== src/etap_ctrl.sv =====
// ---------------------------------------------------------------------------
// ESC arming and pulse generator - controller
// Sequences the shared multiplier, holds the operating mode and the
// result-valid flag, and runs the input/output handshakes.
// ---------------------------------------------------------------------------
module etap_ctrl import etap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output cmd_t              cmd,
  input  stat_t             stat
);

  state_t state;
  state_t state_next;
  mode_t  mode;
  mode_t  mode_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Next state, mode and result flag
  always_comb begin
    state_next = state;
    mode_next  = mode;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind) inside
            KIND_UPDATE: state_next = ST_MUL_F;
            KIND_FAILSAFE, KIND_START: begin
              state_next = ST_NEUT;
              mode_next  = MODE_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_MUL_F: state_next = ST_MUL_T;
      ST_MUL_T: state_next = ST_FILT;
      ST_FILT: begin
        case (mode)
          MODE_WAIT:  state_next = ST_CHECK;
          MODE_ARMED: state_next = ST_GAIN;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_NEUT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_CHECK: begin
        if (slot_free) begin
          state_next = ST_IDLE;
          if (stat.arm_ok) mode_next = MODE_ARMED;
        end
      end
      ST_GAIN:  state_next = ST_SPAN;
      ST_SPAN:  state_next = ST_RECIP;
      ST_RECIP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.ld_out | (out_valid & ~out_ready);
  end

  // Datapath commands
  always_comb begin
    cmd = '{mul_sel: MS_HOLD, out_sel: OUT_NEUTRAL, default: 1'b0};
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_thr = (in_kind == KIND_UPDATE);
          cmd.clr_f  = (in_kind == KIND_FAILSAFE) || (in_kind == KIND_START);
        end
      end
      ST_MUL_F: cmd.mul_sel = MS_F_INV;
      ST_MUL_T: begin
        cmd.mul_sel = MS_THR;
        cmd.ld_acc  = 1'b1;
      end
      ST_FILT: cmd.ld_f = 1'b1;
      ST_NEUT: cmd.ld_out = slot_free;
      ST_CHECK: begin
        cmd.ld_out    = slot_free;
        cmd.out_armed = stat.arm_ok;
      end
      ST_GAIN:  cmd.mul_sel = MS_GAIN;
      ST_SPAN:  cmd.mul_sel = MS_SPAN;
      ST_RECIP: cmd.mul_sel = MS_RECIP;
      ST_EMIT: begin
        cmd.ld_out    = slot_free;
        cmd.out_sel   = OUT_SCALED;
        cmd.out_armed = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_BOOT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sim/tb_esc_throttle_arming_pulse_gen_core.sv =====
// ---------------------------------------------------------------------------
// Testbench for the ESC arming and pulse generator core
// Sends throttle updates, failsafe and start events over the valid/ready
// channel and checks every pulse/armed beat against the table's expected
// beat or an in-bench model of the EMA filter, the arming logic and the pulse
// mapping. The run starts with a table of directed events, then random
// traffic under several register settings with random back-pressure on both sides.
// ---------------------------------------------------------------------------
module tb_esc_throttle_arming_pulse_gen_core;
  import etap_pkg::*;

  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int STALL_LEN       = 300;  // long receiver hold-off, cycles
  localparam int DRAIN_CYC       = 16;   // longest latency plus margin
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam longint F_MAX       = 64'sd67108863;
  localparam longint F_MIN       = -64'sd67108864;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_us;
    logic               armed;
  } pulse_beat_t;

  // directed row: kind, throttle, typed result present, pulse, armed
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    int                 thr;
    bit                 typed;
    logic [PULSE_W-1:0] pulse_us;
    bit                 armed;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [22] = '{
    '{KIND_UPDATE,    1000, 1'b0, 12'd0,    1'b0},  // boot: no beat
    '{KIND_UPDATE,   -1024, 1'b0, 12'd0,    1'b0},  // boot: no beat
    '{KIND_UNUSED,    1023, 1'b0, 12'd0,    1'b0},  // ignored
    '{KIND_START,        0, 1'b1, 12'd1500, 1'b0},
    '{KIND_UPDATE,       0, 1'b1, 12'd1500, 1'b1},  // zero filter arms
    '{KIND_UPDATE,    1000, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,    1000, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,    1023, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,    1023, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,   -1024, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,   -1000, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,   -1000, 1'b0, 12'd0,    1'b0},
    '{KIND_UNUSED,      -1, 1'b0, 12'd0,    1'b0},  // ignored while armed
    '{KIND_FAILSAFE,     0, 1'b1, 12'd1500, 1'b0},
    '{KIND_UPDATE,    1000, 1'b1, 12'd1500, 1'b0},  // far from neutral
    '{KIND_UPDATE,   -1000, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,       0, 1'b0, 12'd0,    1'b0},
    '{KIND_FAILSAFE,    -1, 1'b1, 12'd1500, 1'b0},
    '{KIND_START,     1023, 1'b1, 12'd1500, 1'b0},
    '{KIND_START,    -1024, 1'b1, 12'd1500, 1'b0},  // start while waiting
    '{KIND_UPDATE,      49, 1'b0, 12'd0,    1'b0},
    '{KIND_UPDATE,     255, 1'b0, 12'd0,    1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  etap_in_if  in_ch ();
  etap_out_if out_ch ();

  esc_throttle_arming_pulse_gen_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in       (in_ch),
    .out      (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // model state and register copies
  mode_t  pred_mode;
  longint filt_q;
  longint alpha_r, deadband_r, gain_r, min_r, max_r, neutral_r;

  pulse_beat_t pending_pulses [$];
  int          mismatch_cnt = 0;
  int          idle_mode    = 0;  // 0: rx idles most, 1: tx idles most, 2: none
  int          stall_req_cnt  = 0;
  int          stall_done_cnt = 0;
  int          stick          = 0;  // slowly moving throttle position

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #4000000;
    $display("esc_throttle_arming_pulse_gen_core: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_cnt++;
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // EMA filter, arming and pulse mapping; returns 1 when a beat is due
  function automatic bit predict_pulse(input logic [KIND_W-1:0] k,
                                       input logic signed [THR_W-1:0] t,
                                       output pulse_beat_t res);
    longint thr_l, acc, nf, mag, prod, x, p;
    res = '0;
    if (k == KIND_FAILSAFE || k == KIND_START) begin
      filt_q       = 0;
      pred_mode    = MODE_WAIT;
      res.pulse_us = neutral_r[PULSE_W-1:0];
      return 1'b1;
    end
    if (k != KIND_UPDATE) return 1'b0;

    // filter step, round half up, saturate to Q11.16
    thr_l = longint'(t);
    acc   = filt_q * (65536 - alpha_r) + thr_l * 65536 * alpha_r;
    nf    = (acc + 32768) >>> 16;
    if (nf > F_MAX) nf = F_MAX;
    if (nf < F_MIN) nf = F_MIN;
    filt_q = nf;

    if (pred_mode == MODE_WAIT) begin
      mag = (nf < 0) ? -nf : nf;
      if (mag < deadband_r * 65536) pred_mode = MODE_ARMED;
      res.pulse_us = neutral_r[PULSE_W-1:0];
      res.armed    = (pred_mode == MODE_ARMED);
      return 1'b1;
    end
    if (pred_mode != MODE_ARMED) return 1'b0;

    // gain, truncate toward zero, map -1000..1000 onto min..max, clamp
    prod = nf * gain_r;
    x    = (prod >= 0) ? (prod >>> 31) : -((-prod) >>> 31);
    p    = (x + 1000) * (max_r - min_r) / 2000 + min_r;
    if (p < min_r) p = min_r;
    else if (p > max_r) p = max_r;
    res.pulse_us = p[PULSE_W-1:0];
    res.armed    = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit tx_idle();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 29;
      1:       return $urandom_range(0, 99) < 68;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit rx_idle();
    case (idle_mode)
      0:       return $urandom_range(0, 99) < 68;
      1:       return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  // offer one beat, wait for acceptance, queue the expected result
  task automatic send_item(input logic [KIND_W-1:0] k, input logic signed [THR_W-1:0] t,
                           input bit typed, input pulse_beat_t typed_res);
    pulse_beat_t res;
    bit          has_res;
    bit          rdy;
    while (tx_idle()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.throttle <= t;
    // ready decodes the state register only: its mid-cycle value is the one the next edge sees
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    has_res = predict_pulse(k, t, res);
    if (has_res) pending_pulses.push_back(typed ? typed_res : res);
  endtask

  // stop offering until every result is back and the core has gone quiet
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      CFG_ALPHA:    alpha_r    = val & 16'hFFFF;
      CFG_DEADBAND: deadband_r = val & 10'h3FF;
      CFG_GAIN:     gain_r     = val & 16'hFFFF;
      CFG_MIN:      min_r      = val & 12'hFFF;
      CFG_MAX:      max_r      = val & 12'hFFF;
      CFG_NEUTRAL:  neutral_r  = val & 12'hFFF;
      default: ;
    endcase
  endtask

  // register set per phase: fixed extremes first, then random
  task automatic program_config(input int ph);
    int lo, hi, tmp;
    case (ph)
      1: begin
        cfg_write(CFG_ALPHA, 65535);
        cfg_write(CFG_DEADBAND, 1000);
        cfg_write(CFG_GAIN, 32768);
        cfg_write(CFG_MIN, 0);
        cfg_write(CFG_MAX, 4095);
        cfg_write(CFG_NEUTRAL, 4095);
      end
      2: begin
        // frozen filter, arms at once, inverted clamp range
        cfg_write(CFG_ALPHA, 0);
        cfg_write(CFG_DEADBAND, 1023);
        cfg_write(CFG_GAIN, 0);
        cfg_write(CFG_MIN, 4095);
        cfg_write(CFG_MAX, 0);
        cfg_write(CFG_NEUTRAL, 0);
      end
      3: begin
        // zero deadband: never arms
        cfg_write(CFG_ALPHA, 32768);
        cfg_write(CFG_DEADBAND, 0);
        cfg_write(CFG_GAIN, 16384);
        cfg_write(CFG_MIN, 1000);
        cfg_write(CFG_MAX, 2000);
        cfg_write(CFG_NEUTRAL, 1500);
      end
      default: begin
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
        cfg_write(CFG_ALPHA, $urandom_range(0, 65535));
        cfg_write(CFG_DEADBAND, $urandom_range(0, 1023));
        cfg_write(CFG_GAIN, $urandom_range(0, 32768));
        cfg_write(CFG_MIN, lo);
        cfg_write(CFG_MAX, hi);
        cfg_write(CFG_NEUTRAL, $urandom_range(0, 4095));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // random event: mostly stick motion, centering while waiting, some events
  task automatic gen_item(output logic [KIND_W-1:0] k, output logic signed [THR_W-1:0] t);
    int r, v;
    r = $urandom_range(0, 99);
    v = int'($urandom_range(0, 2047)) - 1024;
    k = KIND_UPDATE;
    if (pred_mode == MODE_BOOT && r < 30) k = KIND_START;
    else if (r < 2) k = KIND_FAILSAFE;
    else if (r < 4) k = KIND_START;
    else if (r < 6) k = KIND_UNUSED;
    else if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       v = -1024;
        1:       v = -1000;
        2:       v = 1000;
        default: v = 1023;
      endcase
    end else if (pred_mode == MODE_WAIT && r < 80) begin
      v = int'($urandom_range(0, 100)) - 50;
    end else begin
      if ($urandom_range(0, 99) < 10) stick = int'($urandom_range(0, 2047)) - 1024;
      else stick += int'($urandom_range(0, 100)) - 50;
      if (stick > 1023) stick = 1023;
      if (stick < -1024) stick = -1024;
      v = stick;
    end
    t = v[THR_W-1:0];
  endtask

  // receiver: check accepted beats, drive ready, one long hold-off on request
  initial begin
    pulse_beat_t        want;
    bit                 took;
    logic [PULSE_W-1:0] got_pulse;
    logic               got_armed;
    out_ch.ready <= 1'b0;
    forever begin
      // valid and payload are registered: sample them mid-cycle
      @(negedge clk);
      took      = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      got_pulse = out_ch.pulse_us;
      got_armed = out_ch.armed;
      @(posedge clk);
      if (took) begin
        if (pending_pulses.size() == 0) begin
          report_mismatch("beat with no result pending", got_pulse, 0);
        end else begin
          want = pending_pulses.pop_front();
          if (got_pulse !== want.pulse_us)
            report_mismatch("pulse_us", got_pulse, want.pulse_us);
          if (got_armed !== want.armed)
            report_mismatch("armed", got_armed, want.armed);
        end
      end
      if (stall_done_cnt < stall_req_cnt) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
        stall_done_cnt++;
      end else begin
        out_ch.ready <= !rx_idle();
      end
    end
  end

  // stimulus
  initial begin
    pulse_beat_t             typed_beat;
    logic [KIND_W-1:0]       k;
    logic signed [THR_W-1:0] t;
    int                      ph, n, wait_cyc;

    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_UPDATE;
    in_ch.throttle <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ALPHA;
    cfg_data       <= '0;

    pred_mode  = MODE_BOOT;
    filt_q     = 0;
    alpha_r    = RST_ALPHA;
    deadband_r = RST_DEADBAND;
    gain_r     = RST_GAIN;
    min_r      = RST_MIN;
    max_r      = RST_MAX;
    neutral_r  = RST_NEUTRAL;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      typed_beat.pulse_us = DIR_TAB[i].pulse_us;
      typed_beat.armed    = DIR_TAB[i].armed;
      send_item(DIR_TAB[i].kind, DIR_TAB[i].thr[THR_W-1:0], DIR_TAB[i].typed, typed_beat);
    end

    // random phases, one register setting each
    typed_beat = '0;
    for (ph = 0; ph < PHASES; ph++) begin
      idle_mode = ph * 3 / PHASES;
      if (ph > 0) begin
        quiesce();
        program_config(ph);
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if (ph == 6 && n == 20) stall_req_cnt++;
        if (ph == 4 && n == 60) quiesce();
        gen_item(k, t);
        send_item(k, t, 1'b0, typed_beat);
        if (k != KIND_UNUSED) n++;
      end
    end

    // drain
    in_ch.valid <= 1'b0;
    for (wait_cyc = 0; wait_cyc < 5000 && pending_pulses.size() != 0; wait_cyc++)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_pulses.size() != 0)
      report_mismatch("results never delivered", pending_pulses.size(), 0);

    if (mismatch_cnt == 0)
      $display("esc_throttle_arming_pulse_gen_core: match");
    else
      $display("esc_throttle_arming_pulse_gen_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/etap_pkg.sv
src/etap_if.sv
src/etap_dp.sv
src/etap_ctrl.sv
src/esc_throttle_arming_pulse_gen_core.sv
sim/tb_esc_throttle_arming_pulse_gen_core.sv
